>>> rtl/smx_pkg.sv
package smx_pkg;

	// request kinds carried in req_type
	localparam logic REQ_EFFECT = 1'b0;
	localparam logic REQ_MUSIC  = 1'b1;

	// volume limits
	localparam logic [7:0] VOL_CAP      = 8'd255;
	localparam logic [8:0] MASTER_UNITY = 9'd256;

	// effect clamp bounds at frame end, 24-bit signed
	localparam logic signed [23:0] EFF_HI = 24'sd8388352;
	localparam logic signed [23:0] EFF_LO = -24'sd8388608;

	// int16 limits
	localparam logic signed [15:0] OUT_HI = 16'sh7fff;
	localparam logic signed [15:0] OUT_LO = 16'sh8000;

	// input transaction
	typedef struct packed {
		logic               req_type;
		logic signed [15:0] sample;
		logic [8:0]         chan_left_vol;
		logic [8:0]         chan_right_vol;
		logic signed [23:0] music_left;
		logic signed [23:0] music_right;
		logic               frame_end;
	} in_item_t;

	// result transaction
	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
	} out_item_t;

	// classified command between front and back
	typedef struct packed {
		logic               req_type;
		logic signed [15:0] sample;
		logic [7:0]         left_gain;
		logic [7:0]         right_gain;
		logic signed [23:0] music_left;
		logic signed [23:0] music_right;
		logic               frame_end;
	} cmd_t;

endpackage

>>> rtl/smx_fifo.sv
module smx_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [WIDTH-1:0]                 wr_data,
	input  logic                             rd_en,
	output logic [WIDTH-1:0]                 rd_data,
	output logic                             full,
	output logic                             empty,
	output logic [$clog2(DEPTH+1)-1:0]       count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/smx_front.sv
module smx_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [8:0]       cfg_wdata,
	input  smx_pkg::in_item_t item,
	output smx_pkg::cmd_t    cmd
);

	logic [8:0]  master_q;
	logic [8:0]  master_eff;
	logic [7:0]  left_cap;
	logic [7:0]  right_cap;
	logic [16:0] left_prod;
	logic [16:0] right_prod;

	// master volume register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= smx_pkg::MASTER_UNITY;
		end else if (cfg_we) begin
			master_q <= cfg_wdata;
		end
	end

	// cap channel and master volumes
	assign master_eff = (master_q > smx_pkg::MASTER_UNITY) ? smx_pkg::MASTER_UNITY : master_q;
	assign left_cap   = (item.chan_left_vol > 9'(smx_pkg::VOL_CAP)) ?
		smx_pkg::VOL_CAP : item.chan_left_vol[7:0];
	assign right_cap  = (item.chan_right_vol > 9'(smx_pkg::VOL_CAP)) ?
		smx_pkg::VOL_CAP : item.chan_right_vol[7:0];

	// scale by master, drop eight fraction bits
	assign left_prod  = left_cap * master_eff;
	assign right_prod = right_cap * master_eff;

	// classified command
	always_comb begin
		cmd.req_type    = item.req_type;
		cmd.sample      = item.sample;
		cmd.left_gain   = left_prod[15:8];
		cmd.right_gain  = right_prod[15:8];
		cmd.music_left  = item.music_left;
		cmd.music_right = item.music_right;
		cmd.frame_end   = item.frame_end;
	end

endmodule

>>> rtl/smx_back.sv
module smx_back #(
	parameter int RES_DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  smx_pkg::cmd_t                    cmd,
	input  logic                             cmd_empty,
	output logic                             cmd_pop,
	input  logic [$clog2(RES_DEPTH+1)-1:0]   res_count,
	output logic                             res_push,
	output smx_pkg::out_item_t               res
);

	localparam int CW = $clog2(RES_DEPTH+1);
	localparam int PW = CW + 2;

	// stage 1: products
	logic               valid_s1;
	logic               type_s1;
	logic               end_s1;
	logic signed [24:0] prod_l_s1;
	logic signed [24:0] prod_r_s1;
	logic signed [23:0] mus_l_s1;
	logic signed [23:0] mus_r_s1;

	// running sums
	logic signed [39:0] eff_l_q;
	logic signed [39:0] eff_r_q;
	logic signed [31:0] mus_l_q;
	logic signed [31:0] mus_r_q;

	// stage 2: frame totals
	logic               valid_s2;
	logic signed [39:0] eff_l_s2;
	logic signed [39:0] eff_r_s2;
	logic signed [31:0] mus_l_s2;
	logic signed [31:0] mus_r_s2;

	// stage 3: clamped effect
	logic               valid_s3;
	logic signed [23:0] eff_l_s3;
	logic signed [23:0] eff_r_s3;
	logic signed [31:0] mus_l_s3;
	logic signed [31:0] mus_r_s3;

	logic signed [39:0] eff_l_nx;
	logic signed [39:0] eff_r_nx;
	logic signed [31:0] mus_l_nx;
	logic signed [31:0] mus_r_nx;
	logic [PW-1:0]      pending;

	function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
		logic signed [39:0] r;
		if (v[40] != v[39]) begin
			r = v[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
		end else begin
			r = v[39:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [23:0] clamp_eff(input logic signed [39:0] v);
		logic signed [23:0] r;
		if (v > 40'(smx_pkg::EFF_HI)) begin
			r = smx_pkg::EFF_HI;
		end else if (v < 40'(smx_pkg::EFF_LO)) begin
			r = smx_pkg::EFF_LO;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] finish(input logic signed [23:0] e,
		input logic signed [31:0] m);
		logic signed [32:0] t;
		logic signed [24:0] s;
		logic signed [15:0] r;
		t = 33'(e) + 33'(m);
		s = t[32:8];
		if (s[24:15] == '0 || s[24:15] == '1) begin
			r = s[15:0];
		end else begin
			r = s[24] ? smx_pkg::OUT_LO : smx_pkg::OUT_HI;
		end
		return r;
	endfunction

	// reserve room in the result queue for every frame still in flight
	assign pending = PW'(res_count) + PW'(valid_s1 & end_s1) + PW'(valid_s2) + PW'(valid_s3);
	assign cmd_pop = ~cmd_empty & (pending < PW'(RES_DEPTH));

	// stage 1: sample times scaled gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			type_s1   <= cmd.req_type;
			end_s1    <= cmd.frame_end;
			prod_l_s1 <= cmd.sample * $signed({1'b0, cmd.left_gain});
			prod_r_s1 <= cmd.sample * $signed({1'b0, cmd.right_gain});
			mus_l_s1  <= cmd.music_left;
			mus_r_s1  <= cmd.music_right;
		end
	end

	// saturating accumulation
	always_comb begin
		eff_l_nx = eff_l_q;
		eff_r_nx = eff_r_q;
		mus_l_nx = mus_l_q;
		mus_r_nx = mus_r_q;
		if (type_s1 == smx_pkg::REQ_EFFECT) begin
			eff_l_nx = sat40(41'(eff_l_q) + 41'(prod_l_s1));
			eff_r_nx = sat40(41'(eff_r_q) + 41'(prod_r_s1));
		end else begin
			mus_l_nx = sat32(33'(mus_l_q) + 33'(mus_l_s1));
			mus_r_nx = sat32(33'(mus_r_q) + 33'(mus_r_s1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_l_q  <= '0;
			eff_r_q  <= '0;
			mus_l_q  <= '0;
			mus_r_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 & end_s1;
			if (valid_s1) begin
				if (end_s1) begin
					eff_l_q <= '0;
					eff_r_q <= '0;
					mus_l_q <= '0;
					mus_r_q <= '0;
				end else begin
					eff_l_q <= eff_l_nx;
					eff_r_q <= eff_r_nx;
					mus_l_q <= mus_l_nx;
					mus_r_q <= mus_r_nx;
				end
			end
		end
	end

	// capture frame totals
	always_ff @(posedge clk) begin
		if (valid_s1 && end_s1) begin
			eff_l_s2 <= eff_l_nx;
			eff_r_s2 <= eff_r_nx;
			mus_l_s2 <= mus_l_nx;
			mus_r_s2 <= mus_r_nx;
		end
	end

	// stage 3: clamp effect sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			eff_l_s3 <= clamp_eff(eff_l_s2);
			eff_r_s3 <= clamp_eff(eff_r_s2);
			mus_l_s3 <= mus_l_s2;
			mus_r_s3 <= mus_r_s2;
		end
	end

	// stage 4: add music, shift, saturate
	assign res_push      = valid_s3;
	assign res.left_out  = finish(eff_l_s3, mus_l_s3);
	assign res.right_out = finish(eff_r_s3, mus_r_s3);

endmodule

>>> rtl/stereo_channel_mixer.sv
// channel    direction  handshake          payload
// item       in         push / full        smx_pkg::in_item_t
// frame      out        pop / empty        smx_pkg::out_item_t
// cfg        in         cfg_we             master_volume, 9 bits
//
// one contribution is taken per cycle while full is low; the back end retires one
// command a cycle through its multiply and accumulate stages while the result queue has room.
// a frame result reaches the result queue once its frame_end transaction has passed
// the command queue and the stage 1, stage 2 and stage 3 registers.
// reset clears the queues, the running sums and sets master volume to unity.
// full rises when the command queue fills; the back end stops draining it while
// the result queue has no room left for the frames already in flight.
module stereo_channel_mixer #(
	parameter int CMD_DEPTH = 4,
	parameter int RES_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  smx_pkg::in_item_t   item,
	output logic                empty,
	input  logic                pop,
	output smx_pkg::out_item_t  frame,
	input  logic                cfg_we,
	input  logic [8:0]          cfg_wdata
);

	localparam int CMD_W = $bits(smx_pkg::cmd_t);
	localparam int RES_W = $bits(smx_pkg::out_item_t);

	smx_pkg::cmd_t                    cmd_in;
	smx_pkg::cmd_t                    cmd_head;
	smx_pkg::out_item_t               res;
	logic                             cmd_empty;
	logic                             cmd_pop;
	logic                             res_push;
	logic                             res_full;
	logic [$clog2(RES_DEPTH+1)-1:0]   res_count;
	logic [$clog2(CMD_DEPTH+1)-1:0]   cmd_count;
	logic                             cmd_busy;

	// front: master register and volume scaling
	smx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.cmd       (cmd_in)
	);

	// command queue between front and back
	smx_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.full    (full),
		.empty   (cmd_empty),
		.count   (cmd_count)
	);

	assign cmd_busy = (cmd_count != '0);

	// back: multiply, accumulate, finish; credit scheme keeps the result queue
	// from overflowing, a full result queue also holds the command queue
	smx_back #(
		.RES_DEPTH (RES_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty | ~cmd_busy | res_full),
		.cmd_pop   (cmd_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res       (res)
	);

	// result queue
	smx_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res),
		.rd_en   (pop),
		.rd_data (frame),
		.full    (res_full),
		.empty   (empty),
		.count   (res_count)
	);

endmodule

>>> sim/stereo_channel_mixer_tb.sv
module stereo_channel_mixer_tb;

	// effect clamp at frame end and accumulator limits
	localparam longint EFF_CLAMP_HI = 64'sd32767 * 256;
	localparam longint EFF_CLAMP_LO = -(64'sd32768 * 256);
	localparam longint ACC40_HI = (64'sd1 <<< 39) - 1;
	localparam longint ACC40_LO = -(64'sd1 <<< 39);
	localparam longint ACC32_HI = (64'sd1 <<< 31) - 1;
	localparam longint ACC32_LO = -(64'sd1 <<< 31);
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	smx_pkg::in_item_t  item = '0;
	logic               empty;
	logic               pop = 1'b0;
	smx_pkg::out_item_t frame;
	logic               cfg_we = 1'b0;
	logic [8:0]         cfg_wdata = '0;
	logic               hold_off = 1'b0;

	// mixer state as the testbench sees it
	logic [8:0] mix_master = smx_pkg::MASTER_UNITY;
	longint     eff_left_acc = 0;
	longint     eff_right_acc = 0;
	longint     mus_left_acc = 0;
	longint     mus_right_acc = 0;

	smx_pkg::in_item_t  pending_items[$];
	smx_pkg::out_item_t expected_frames[$];
	int         items_taken = 0;
	int         frames_checked = 0;
	int         error_count = 0;
	int         settings_used = 1;
	int         burst_left = 0;
	int         gap_left = 0;
	logic [15:0] pop_pattern = 16'hffff;
	logic [3:0]  pop_phase = '0;

	stereo_channel_mixer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.frame     (frame),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic longint clamp(longint x, longint lo, longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	// channel volume capped, then scaled by the capped master volume
	function automatic longint channel_gain(logic [8:0] vol);
		longint c;
		longint m;
		c = (vol > 9'd255) ? 255 : longint'(vol);
		m = (mix_master > smx_pkg::MASTER_UNITY) ? 256 : longint'(mix_master);
		return (c * m) >>> 8;
	endfunction

	// clamp effect, add music, floor shift by 8, saturate to int16
	function automatic logic signed [15:0] side_output(longint eff, longint mus);
		longint t;
		longint s;
		t = clamp(eff, EFF_CLAMP_LO, EFF_CLAMP_HI) + mus;
		s = clamp(t >>> 8, -32768, 32767);
		return s[15:0];
	endfunction

	// accumulate one contribution, close the frame on frame_end
	task automatic mix_contribution(input smx_pkg::in_item_t it);
		longint s;
		smx_pkg::out_item_t res;
		if (it.req_type == smx_pkg::REQ_EFFECT) begin
			s = $signed(it.sample);
			eff_left_acc = clamp(eff_left_acc + s * channel_gain(it.chan_left_vol),
				ACC40_LO, ACC40_HI);
			eff_right_acc = clamp(eff_right_acc + s * channel_gain(it.chan_right_vol),
				ACC40_LO, ACC40_HI);
		end else begin
			mus_left_acc = clamp(mus_left_acc + longint'($signed(it.music_left)),
				ACC32_LO, ACC32_HI);
			mus_right_acc = clamp(mus_right_acc + longint'($signed(it.music_right)),
				ACC32_LO, ACC32_HI);
		end
		if (it.frame_end) begin
			res.left_out = side_output(eff_left_acc, mus_left_acc);
			res.right_out = side_output(eff_right_acc, mus_right_acc);
			expected_frames.push_back(res);
			eff_left_acc = 0;
			eff_right_acc = 0;
			mus_left_acc = 0;
			mus_right_acc = 0;
		end
	endtask

	function automatic smx_pkg::in_item_t make_item(logic kind, logic [15:0] smp,
			logic [8:0] lv, logic [8:0] rv, logic [23:0] ml, logic [23:0] mr,
			logic last);
		smx_pkg::in_item_t it;
		it.req_type = kind;
		it.sample = smp;
		it.chan_left_vol = lv;
		it.chan_right_vol = rv;
		it.music_left = ml;
		it.music_right = mr;
		it.frame_end = last;
		return it;
	endfunction

	// volumes biased towards zero, the cap and beyond
	function automatic logic [8:0] pick_vol();
		case ($urandom_range(0, 7))
			0: return 9'd0;
			1: return 9'd255;
			2: return 9'd256;
			3: return 9'd511;
			default: return 9'($urandom_range(0, 511));
		endcase
	endfunction

	function automatic logic [23:0] pick_music();
		case ($urandom_range(0, 5))
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return 24'($signed(32'($urandom_range(0, 1023))) - 512);
			default: return 24'($urandom);
		endcase
	endfunction

	// every field but frame_end random, whatever the kind
	function automatic smx_pkg::in_item_t rand_item();
		smx_pkg::in_item_t it;
		logic [15:0] smp;
		case ($urandom_range(0, 4))
			0: smp = 16'h7fff;
			1: smp = 16'h8000;
			default: smp = 16'($urandom);
		endcase
		it = make_item($urandom_range(0, 1) ? smx_pkg::REQ_MUSIC : smx_pkg::REQ_EFFECT,
			smp, pick_vol(), pick_vol(), pick_music(), pick_music(), 1'b0);
		return it;
	endfunction

	task automatic queue_frame(input int len);
		smx_pkg::in_item_t it;
		for (int i = 0; i < len; i++) begin
			it = rand_item();
			it.frame_end = (i == len - 1);
			pending_items.push_back(it);
		end
	endtask

	// random frames, mostly short, now and then long
	task automatic queue_frames(input int n_items);
		int left;
		int len;
		left = n_items;
		while (left > 0) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
			if (len > left)
				len = left;
			queue_frame(len);
			left -= len;
		end
	endtask

	// music sums pushed past the 32-bit limits, left up and right down
	task automatic queue_music_flood();
		smx_pkg::in_item_t it;
		for (int i = 0; i < 270; i++) begin
			it = rand_item();
			it.req_type = smx_pkg::REQ_MUSIC;
			it.music_left = 24'h7fffff;
			it.music_right = 24'h800000;
			pending_items.push_back(it);
		end
		it = make_item(smx_pkg::REQ_EFFECT, 16'h8000, 9'd255, 9'd511, '0, '0, 1'b1);
		pending_items.push_back(it);
	endtask

	// wait until every transaction is through and the pipeline is quiet
	task automatic settle();
		while (pending_items.size() != 0 || push || expected_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_master(input logic [8:0] v);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		mix_master = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
		end else begin
			if (push && !full) begin
				mix_contribution(item);
				void'(pending_items.pop_front());
				items_taken++;
				burst_left--;
			end
			if (!(push && full)) begin
				if (burst_left <= 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (pending_items.size() > 0) begin
					push <= 1'b1;
					item <= pending_items[0];
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// receiver: check each frame transaction, stall on a rolling pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_frames.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected frame: left %0d right %0d",
							frame.left_out, frame.right_out);
				end else begin
					if (frame.left_out !== expected_frames[0].left_out ||
						frame.right_out !== expected_frames[0].right_out) begin
						error_count++;
						if (error_count <= 10)
							$display("frame %0d mismatch: expected %0d/%0d got %0d/%0d",
								frames_checked, expected_frames[0].left_out,
								expected_frames[0].right_out, frame.left_out,
								frame.right_out);
					end
					void'(expected_frames.pop_front());
					frames_checked++;
				end
			end
			if (pop_phase == 0) begin
				if ($urandom_range(0, 3) == 0)
					pop_pattern = 16'hffff;
				else
					pop_pattern = 16'($urandom);
			end
			pop <= !hold_off && pop_pattern[pop_phase];
			pop_phase = pop_phase + 4'd1;
		end
	end

	// long receiver hold-offs while the sender keeps going
	initial begin
		for (int k = 0; k < 2; k++) begin
			while (items_taken < 260 + 400 * k)
				@(posedge clk);
			hold_off <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_off <= 1'b0;
		end
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// stimulus and end of run
	initial begin
		logic [8:0] settings[8];
		settings = '{9'd0, 9'd511, 9'd300, 9'd1, 9'd128, 9'd256, 9'd0, 9'd255};
		settings[6] = 9'($urandom_range(2, 510));
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames at unity master volume
		pending_items.push_back(make_item(smx_pkg::REQ_EFFECT, 16'h7fff, 9'd511, 9'd255,
			'0, '0, 1'b1));
		pending_items.push_back(make_item(smx_pkg::REQ_EFFECT, 16'h8000, 9'd256, 9'd0,
			'0, '0, 1'b1));
		pending_items.push_back(make_item(smx_pkg::REQ_MUSIC, '0, '0, '0,
			24'h7fffff, 24'h800000, 1'b1));
		pending_items.push_back(make_item(smx_pkg::REQ_EFFECT, '0, '0, '0, '0, '0, 1'b1));
		// effect sums past the positive clamp
		pending_items.push_back(make_item(smx_pkg::REQ_EFFECT, 16'h7fff, 9'd255, 9'd255,
			'0, '0, 1'b0));
		pending_items.push_back(make_item(smx_pkg::REQ_EFFECT, 16'h7fff, 9'd255, 9'd255,
			'0, '0, 1'b0));
		pending_items.push_back(make_item(smx_pkg::REQ_MUSIC, '0, '0, '0,
			24'h000100, 24'hffff00, 1'b1));
		// and past the negative clamp
		pending_items.push_back(make_item(smx_pkg::REQ_EFFECT, 16'h8000, 9'd255, 9'd255,
			'0, '0, 1'b0));
		pending_items.push_back(make_item(smx_pkg::REQ_EFFECT, 16'h8000, 9'd255, 9'd255,
			'0, '0, 1'b0));
		pending_items.push_back(make_item(smx_pkg::REQ_EFFECT, 16'h8000, 9'd1, 9'd1,
			'0, '0, 1'b1));
		// small negatives round towards minus infinity
		pending_items.push_back(make_item(smx_pkg::REQ_EFFECT, 16'hffff, 9'd1, 9'd511,
			'0, '0, 1'b1));
		pending_items.push_back(make_item(smx_pkg::REQ_MUSIC, '0, '0, '0,
			24'hffffff, 24'h000001, 1'b1));
		pending_items.push_back(make_item(smx_pkg::REQ_MUSIC, '0, '0, '0,
			24'h0000ff, 24'hffff00, 1'b0));
		pending_items.push_back(make_item(smx_pkg::REQ_EFFECT, 16'h0001, 9'd1, 9'd1,
			'0, '0, 1'b1));
		settle();

		// random frames under a range of master volumes
		foreach (settings[i]) begin
			write_master(settings[i]);
			queue_frames(65);
			if (i == 5)
				queue_music_flood();
		end
		settle();

		$display("%0d contributions mixed into %0d checked frames under %0d master settings",
			items_taken, frames_checked, settings_used);
		$display("sums driven into clamp and saturation, result side held off twice");
		if (error_count == 0 && expected_frames.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
